>>> rtl/fts_pkg.sv
// Shared widths, register codes, word types and helpers for the fan tach stall monitor.
package fts_pkg;

  localparam int unsigned CMD_W       = 10;
  localparam int unsigned RPM_W       = 16;
  localparam int unsigned TIME_WIDTH  = 10;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_CMD     = 3'd0,
    CFG_MIN_RPM     = 3'd1,
    CFG_GRACE       = 3'd2,
    CFG_LOW_LIMIT   = 3'd3,
    CFG_TIMEOUT     = 3'd4,
    CFG_HEALTHY_LIM = 3'd5,
    CFG_FAN2        = 3'd6
  } cfg_idx_e;

  localparam logic [CMD_W-1:0]       RST_MIN_CMD     = 10'd400;
  localparam logic [RPM_W-1:0]       RST_MIN_RPM     = 16'd200;
  localparam logic [TIME_WIDTH-1:0]  RST_GRACE       = 10'd50;
  localparam logic [COUNT_WIDTH-1:0] RST_LOW_LIMIT   = 16'd10;
  localparam logic [TIME_WIDTH-1:0]  RST_TIMEOUT     = 10'd50;
  localparam logic [COUNT_WIDTH-1:0] RST_HEALTHY_LIM = 16'd20;

  typedef struct packed {
    logic [CMD_W-1:0]       min_command_tenths;
    logic [RPM_W-1:0]       min_valid_rpm;
    logic [TIME_WIDTH-1:0]  spinup_grace_polls;
    logic [COUNT_WIDTH-1:0] low_sample_limit;
    logic [TIME_WIDTH-1:0]  recovery_timeout_polls;
    logic [COUNT_WIDTH-1:0] healthy_sample_limit;
    logic                   second_fan_present;
  } cfg_t;

  typedef struct packed {
    logic             chip_active;
    logic             external_fault;
    logic [CMD_W-1:0] fan_command;
    logic [RPM_W-1:0] fan1_rpm;
    logic [RPM_W-1:0] tach2_rpm;
  } in_word_t;

  typedef struct packed {
    logic recovery_active;
    logic fault_latched;
    logic fault_event;
    logic fault_fan;
  } res_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc_cnt(input logic [COUNT_WIDTH-1:0] v);
    return (v == {COUNT_WIDTH{1'b1}}) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [TIME_WIDTH-1:0] sat_inc_time(input logic [TIME_WIDTH-1:0] v);
    return (v == {TIME_WIDTH{1'b1}}) ? v : v + TIME_WIDTH'(1);
  endfunction

endpackage

>>> rtl/fts_in_if.sv
// Input channel interface carrying one poll word.
interface fts_in_if;
  logic                      valid;
  logic                      ready;
  logic                      chip_active;
  logic                      external_fault;
  logic [fts_pkg::CMD_W-1:0] fan_command;
  logic [fts_pkg::RPM_W-1:0] fan1_rpm;
  logic [fts_pkg::RPM_W-1:0] tach2_rpm;

  modport source (
    output valid, chip_active, external_fault, fan_command, fan1_rpm, tach2_rpm,
    input  ready
  );
  modport sink (
    input  valid, chip_active, external_fault, fan_command, fan1_rpm, tach2_rpm,
    output ready
  );
endinterface

>>> rtl/fts_out_if.sv
// Output channel interface carrying one result word.
interface fts_out_if;
  logic valid;
  logic ready;
  logic recovery_active;
  logic fault_latched;
  logic fault_event;
  logic fault_fan;

  modport source (
    output valid, recovery_active, fault_latched, fault_event, fault_fan,
    input  ready
  );
  modport sink (
    input  valid, recovery_active, fault_latched, fault_event, fault_fan,
    output ready
  );
endinterface

>>> rtl/fan_tach_stall_monitor.sv
// Top level of the fan tachometer stall monitor: input register, core and result register.
//
//   channel  dir  handshake          word
//   in_i     in   valid/ready        lifecycle, fault, command, two rpm readings
//   out_o    out  valid/ready        recovery, latched fault, fault event, fault fan
//   cfg      in   cfg_we_i only      register index and write data
//
// One word is accepted per cycle while in_i.ready is high; a taken poll is held in the
// input register, and its result in the result register until out_o takes it.
// The state update is a single pass of counter and compare logic in fts_core.
// While the result register is full and out_o.ready is low, the input register
// still takes one word; ready drops only when both stages hold a word.
// Reset clears the valid flags, the monitor state and loads the register defaults.
module fan_tach_stall_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fts_in_if.sink                         in_i,
  fts_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [fts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fts_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  fts_pkg::cfg_t     cfg;
  fts_pkg::in_word_t word_q;
  fts_pkg::res_t     res;
  fts_pkg::res_t     res_q;
  logic              in_valid_q, in_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              in_take;
  logic              advance;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  assign in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      word_q.chip_active    <= in_i.chip_active;
      word_q.external_fault <= in_i.external_fault;
      word_q.fan_command    <= in_i.fan_command;
      word_q.fan1_rpm       <= in_i.fan1_rpm;
      word_q.tach2_rpm      <= in_i.tach2_rpm;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  fts_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  fts_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .cfg_i (cfg),
    .word_i(word_q),
    .res_o (res)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.recovery_active = res_q.recovery_active;
  assign out_o.fault_latched   = res_q.fault_latched;
  assign out_o.fault_event     = res_q.fault_event;
  assign out_o.fault_fan       = res_q.fault_fan;

endmodule

>>> rtl/fts_cfg_regs.sv
// Configuration register bank with write-only access.
module fts_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fts_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [fts_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output fts_pkg::cfg_t                       cfg_o
);

  fts_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (fts_pkg::cfg_idx_e'(cfg_idx_i))
        fts_pkg::CFG_MIN_CMD:
          cfg_d.min_command_tenths = cfg_wdata_i[fts_pkg::CMD_W-1:0];
        fts_pkg::CFG_MIN_RPM:
          cfg_d.min_valid_rpm = cfg_wdata_i[fts_pkg::RPM_W-1:0];
        fts_pkg::CFG_GRACE:
          cfg_d.spinup_grace_polls = cfg_wdata_i[fts_pkg::TIME_WIDTH-1:0];
        fts_pkg::CFG_LOW_LIMIT:
          cfg_d.low_sample_limit = cfg_wdata_i[fts_pkg::COUNT_WIDTH-1:0];
        fts_pkg::CFG_TIMEOUT:
          cfg_d.recovery_timeout_polls = cfg_wdata_i[fts_pkg::TIME_WIDTH-1:0];
        fts_pkg::CFG_HEALTHY_LIM:
          cfg_d.healthy_sample_limit = cfg_wdata_i[fts_pkg::COUNT_WIDTH-1:0];
        fts_pkg::CFG_FAN2:
          cfg_d.second_fan_present = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_command_tenths     <= fts_pkg::RST_MIN_CMD;
      cfg_q.min_valid_rpm          <= fts_pkg::RST_MIN_RPM;
      cfg_q.spinup_grace_polls     <= fts_pkg::RST_GRACE;
      cfg_q.low_sample_limit       <= fts_pkg::RST_LOW_LIMIT;
      cfg_q.recovery_timeout_polls <= fts_pkg::RST_TIMEOUT;
      cfg_q.healthy_sample_limit   <= fts_pkg::RST_HEALTHY_LIM;
      cfg_q.second_fan_present     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/fts_core.sv
// Stall monitor state and the per-poll update logic.
module fts_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  fts_pkg::cfg_t     cfg_i,
  input  fts_pkg::in_word_t word_i,
  output fts_pkg::res_t     res_o
);

  logic                            tracking_q, tracking_d;
  logic [fts_pkg::TIME_WIDTH-1:0]  spin_q, spin_d;
  logic [fts_pkg::TIME_WIDTH-1:0]  rec_el_q, rec_el_d;
  logic [fts_pkg::COUNT_WIDTH-1:0] low0_q, low0_d;
  logic [fts_pkg::COUNT_WIDTH-1:0] low1_q, low1_d;
  logic [fts_pkg::COUNT_WIDTH-1:0] healthy_q, healthy_d;
  logic                            in_rec_q, in_rec_d;
  logic                            fault_q, fault_d;
  logic                            validating;
  logic                            is_low1, is_low2;
  logic                            event_d, which_d;

  assign validating = word_i.chip_active && !word_i.external_fault &&
                      (word_i.fan_command >= cfg_i.min_command_tenths);
  assign is_low1 = word_i.fan1_rpm < cfg_i.min_valid_rpm;
  assign is_low2 = cfg_i.second_fan_present && (word_i.tach2_rpm < cfg_i.min_valid_rpm);

  // The update follows the poll step in order; later steps see earlier results.
  always_comb begin
    tracking_d = 1'b0;
    spin_d     = '0;
    rec_el_d   = '0;
    low0_d     = '0;
    low1_d     = '0;
    healthy_d  = '0;
    in_rec_d   = 1'b0;
    fault_d    = 1'b0;
    event_d    = 1'b0;
    which_d    = 1'b0;
    if (validating) begin
      tracking_d = 1'b1;
      spin_d     = tracking_q ? fts_pkg::sat_inc_time(spin_q) : '0;
      rec_el_d   = in_rec_q ? fts_pkg::sat_inc_time(rec_el_q) : rec_el_q;
      low0_d     = low0_q;
      low1_d     = low1_q;
      healthy_d  = healthy_q;
      in_rec_d   = in_rec_q;
      fault_d    = fault_q;
      if (spin_d >= cfg_i.spinup_grace_polls) begin
        low0_d = is_low1 ? fts_pkg::sat_inc_cnt(low0_q) : '0;
        low1_d = is_low2 ? fts_pkg::sat_inc_cnt(low1_q) : '0;
        if (!in_rec_q && !fault_q && ((low0_d >= cfg_i.low_sample_limit) ||
                                      (low1_d >= cfg_i.low_sample_limit))) begin
          in_rec_d  = 1'b1;
          rec_el_d  = '0;
          healthy_d = '0;
        end
      end
      if (in_rec_d) begin
        if (!is_low1 && !is_low2) begin
          healthy_d = fts_pkg::sat_inc_cnt(healthy_d);
          if (healthy_d >= cfg_i.healthy_sample_limit) begin
            in_rec_d = 1'b0;
            spin_d   = '0;
            low0_d   = '0;
            low1_d   = '0;
          end
        end else begin
          healthy_d = '0;
        end
        if (in_rec_d && (rec_el_d >= cfg_i.recovery_timeout_polls)) begin
          in_rec_d = 1'b0;
          rec_el_d = '0;
          fault_d  = 1'b1;
          event_d  = 1'b1;
          which_d  = is_low2;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracking_q <= 1'b0;
      spin_q     <= '0;
      rec_el_q   <= '0;
      low0_q     <= '0;
      low1_q     <= '0;
      healthy_q  <= '0;
      in_rec_q   <= 1'b0;
      fault_q    <= 1'b0;
    end else if (step_i) begin
      tracking_q <= tracking_d;
      spin_q     <= spin_d;
      rec_el_q   <= rec_el_d;
      low0_q     <= low0_d;
      low1_q     <= low1_d;
      healthy_q  <= healthy_d;
      in_rec_q   <= in_rec_d;
      fault_q    <= fault_d;
    end
  end

  assign res_o.recovery_active = in_rec_d;
  assign res_o.fault_latched   = fault_d;
  assign res_o.fault_event     = event_d;
  assign res_o.fault_fan       = which_d;

`ifndef SYNTHESIS
  // Once a fault is raised no kick may run until checking stops.
  a_no_kick_after_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_rec_q && fault_q))
    else $error("recovery kick active while fault is latched");

  a_clear_on_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !validating) |=> (!tracking_q && !in_rec_q && !fault_q &&
                                 low0_q == '0 && low1_q == '0))
    else $error("state not cleared after checking stopped");

  a_event_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.fault_event) |-> (res_o.fault_latched && !res_o.recovery_active))
    else $error("fault event without latched fault or with kick active");

  a_fan_with_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.fault_fan) |-> (res_o.fault_event && cfg_i.second_fan_present))
    else $error("fault fan named without a fault event on fan two");
`endif

endmodule
